@@ rtl/ovl_pkg.sv @@
// shared constants, codes and command/status types for the ordered value list
package ovl_pkg;

  localparam int CAPACITY = 16;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  localparam logic [2:0] KIND_FRONT  = 3'd0;
  localparam logic [2:0] KIND_BACK   = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_SEARCH = 3'd3;
  localparam logic [2:0] KIND_DUMP   = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef logic [2:0] mem_op_t;
  localparam mem_op_t MEM_NONE      = 3'd0;
  localparam mem_op_t MEM_READ      = 3'd1;
  localparam mem_op_t MEM_COPY_UP   = 3'd2;
  localparam mem_op_t MEM_COPY_DN   = 3'd3;
  localparam mem_op_t MEM_PUT_FRONT = 3'd4;
  localparam mem_op_t MEM_PUT_BACK  = 3'd5;

  typedef logic [2:0] idx_op_t;
  localparam idx_op_t IDX_HOLD  = 3'd0;
  localparam idx_op_t IDX_ZERO  = 3'd1;
  localparam idx_op_t IDX_COUNT = 3'd2;
  localparam idx_op_t IDX_INC   = 3'd3;
  localparam idx_op_t IDX_DEC   = 3'd4;
  localparam idx_op_t IDX_HIT   = 3'd5;

  typedef logic [1:0] cnt_op_t;
  localparam cnt_op_t CNT_HOLD = 2'd0;
  localparam cnt_op_t CNT_INC  = 2'd1;
  localparam cnt_op_t CNT_DEC  = 2'd2;

  typedef logic [1:0] item_sel_t;
  localparam item_sel_t ITEM_ZERO  = 2'd0;
  localparam item_sel_t ITEM_VALUE = 2'd1;
  localparam item_sel_t ITEM_RDATA = 2'd2;

  typedef struct packed {
    mem_op_t    mem_op;
    idx_op_t    idx_op;
    cnt_op_t    cnt_op;
    logic       take;
    logic       emit;
    logic [1:0] emit_status;
    item_sel_t  emit_item;
    logic       emit_last;
  } ovl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic idx_zero;
    logic idx_last;
    logic idx_end;
    logic hit;
    logic cmp_last;
    logic out_free;
  } ovl_sts_t;

endpackage

@@ rtl/ovl_in_if.sv @@
// request channel: operation kind and value
interface ovl_in_if;
  logic                              valid;
  logic                              ready;
  logic [2:0]                        kind;
  logic signed [ovl_pkg::DATA_W-1:0] value;

  modport source(output valid, output kind, output value, input ready);
  modport sink(input valid, input kind, input value, output ready);
endinterface

@@ rtl/ovl_out_if.sv @@
// response channel: status, item and last mark
interface ovl_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic signed [ovl_pkg::DATA_W-1:0] item;
  logic                              last;

  modport source(output valid, output status, output item, output last, input ready);
  modport sink(input valid, input status, input item, input last, output ready);
endinterface

@@ rtl/ovl_ctrl.sv @@
// controller state machine for the ordered value list
module ovl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [2:0]        req_kind,
  output logic              req_ready,
  input  ovl_pkg::ovl_sts_t sts,
  output ovl_pkg::ovl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UP   = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DN   = 3'd3;
  localparam logic [2:0] S_DRD  = 3'd4;
  localparam logic [2:0] S_DOUT = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  logic [2:0]         state, state_next;
  logic               is_remove, is_remove_next;
  logic [1:0]         resp_status, resp_status_next;
  ovl_pkg::item_sel_t resp_item, resp_item_next;

  always_comb begin
    cmd              = '0;
    state_next       = state;
    is_remove_next   = is_remove;
    resp_status_next = resp_status;
    resp_item_next   = resp_item;
    req_ready        = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.take = 1'b1;
          unique case (req_kind)
            ovl_pkg::KIND_FRONT, ovl_pkg::KIND_BACK: begin
              resp_item_next = ovl_pkg::ITEM_ZERO;
              if (sts.count_full) begin
                resp_status_next = ovl_pkg::ST_FULL;
                state_next       = S_RESP;
              end else if (req_kind == ovl_pkg::KIND_BACK) begin
                cmd.mem_op       = ovl_pkg::MEM_PUT_BACK;
                cmd.cnt_op       = ovl_pkg::CNT_INC;
                resp_status_next = ovl_pkg::ST_OK;
                state_next       = S_RESP;
              end else begin
                cmd.idx_op       = ovl_pkg::IDX_COUNT;
                resp_status_next = ovl_pkg::ST_OK;
                state_next       = S_UP;
              end
            end
            ovl_pkg::KIND_REMOVE, ovl_pkg::KIND_SEARCH: begin
              if (sts.count_zero) begin
                resp_status_next = ovl_pkg::ST_EMPTY;
                resp_item_next   = ovl_pkg::ITEM_ZERO;
                state_next       = S_RESP;
              end else begin
                cmd.idx_op     = ovl_pkg::IDX_ZERO;
                is_remove_next = (req_kind == ovl_pkg::KIND_REMOVE);
                state_next     = S_SCAN;
              end
            end
            ovl_pkg::KIND_DUMP: begin
              if (sts.count_zero) begin
                resp_status_next = ovl_pkg::ST_EMPTY;
                resp_item_next   = ovl_pkg::ITEM_ZERO;
                state_next       = S_RESP;
              end else begin
                cmd.idx_op = ovl_pkg::IDX_ZERO;
                state_next = S_DRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_UP: begin
        if (sts.idx_zero) begin
          cmd.mem_op = ovl_pkg::MEM_PUT_FRONT;
          cmd.cnt_op = ovl_pkg::CNT_INC;
          state_next = S_RESP;
        end else begin
          cmd.mem_op = ovl_pkg::MEM_COPY_UP;
          cmd.idx_op = ovl_pkg::IDX_DEC;
        end
      end
      S_SCAN: begin
        if (sts.hit) begin
          resp_status_next = ovl_pkg::ST_OK;
          if (is_remove) begin
            resp_item_next = ovl_pkg::ITEM_ZERO;
            cmd.idx_op     = ovl_pkg::IDX_HIT;
            state_next     = S_DN;
          end else begin
            resp_item_next = ovl_pkg::ITEM_VALUE;
            state_next     = S_RESP;
          end
        end else if (sts.cmp_last) begin
          resp_status_next = ovl_pkg::ST_NOT_FOUND;
          resp_item_next   = ovl_pkg::ITEM_ZERO;
          state_next       = S_RESP;
        end else if (!sts.idx_end) begin
          cmd.mem_op = ovl_pkg::MEM_READ;
          cmd.idx_op = ovl_pkg::IDX_INC;
        end
      end
      S_DN: begin
        if (sts.idx_last) begin
          cmd.cnt_op = ovl_pkg::CNT_DEC;
          state_next = S_RESP;
        end else begin
          cmd.mem_op = ovl_pkg::MEM_COPY_DN;
          cmd.idx_op = ovl_pkg::IDX_INC;
        end
      end
      S_DRD: begin
        cmd.mem_op = ovl_pkg::MEM_READ;
        state_next = S_DOUT;
      end
      S_DOUT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ovl_pkg::ST_OK;
          cmd.emit_item   = ovl_pkg::ITEM_RDATA;
          cmd.emit_last   = sts.idx_last;
          if (sts.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.idx_op = ovl_pkg::IDX_INC;
            state_next = S_DRD;
          end
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = resp_status;
          cmd.emit_item   = resp_item;
          cmd.emit_last   = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      is_remove   <= 1'b0;
      resp_status <= ovl_pkg::ST_OK;
      resp_item   <= ovl_pkg::ITEM_ZERO;
    end else begin
      state       <= state_next;
      is_remove   <= is_remove_next;
      resp_status <= resp_status_next;
      resp_item   <= resp_item_next;
    end
  end

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && cmd.emit_last |=> state == S_IDLE)
    else $error("last word not followed by idle");

endmodule

@@ rtl/ovl_dpath.sv @@
// datapath: list memory, count, walk index, compare and response register
module ovl_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  logic signed [ovl_pkg::DATA_W-1:0] req_value,
  input  ovl_pkg::ovl_cmd_t                 cmd,
  output ovl_pkg::ovl_sts_t                 sts,
  ovl_out_if.source                         rsp
);

  logic [ovl_pkg::DATA_W-1:0] mem [ovl_pkg::CAPACITY];
  logic [ovl_pkg::DATA_W-1:0] rdata;
  logic [ovl_pkg::DATA_W-1:0] val;
  logic [ovl_pkg::CNT_W-1:0]  count;
  logic [ovl_pkg::CNT_W-1:0]  idx;
  logic [ovl_pkg::CNT_W-1:0]  idx_m1, idx_p1, count_m1;
  logic [ovl_pkg::ADDR_W-1:0] raddr;
  logic                       re;
  logic                       wv, wv_next;
  logic [ovl_pkg::ADDR_W-1:0] waddr, waddr_next;
  logic                       wput, wput_next;
  logic                       cmp_valid;
  logic [ovl_pkg::CNT_W-1:0]  cmp_idx;
  logic                       out_valid;
  logic [1:0]                 out_status;
  logic [ovl_pkg::DATA_W-1:0] out_item, item_mux;
  logic                       out_last;
  logic                       out_free;

  assign idx_m1   = idx - ovl_pkg::CNT_W'(1);
  assign idx_p1   = idx + ovl_pkg::CNT_W'(1);
  assign count_m1 = count - ovl_pkg::CNT_W'(1);
  assign out_free = !out_valid || rsp.ready;

  // read address and delayed write stage
  always_comb begin
    raddr      = idx[ovl_pkg::ADDR_W-1:0];
    re         = 1'b0;
    wv_next    = 1'b0;
    waddr_next = idx[ovl_pkg::ADDR_W-1:0];
    wput_next  = 1'b0;
    unique case (cmd.mem_op)
      ovl_pkg::MEM_READ: begin
        re = 1'b1;
      end
      ovl_pkg::MEM_COPY_UP: begin
        raddr   = idx_m1[ovl_pkg::ADDR_W-1:0];
        re      = 1'b1;
        wv_next = 1'b1;
      end
      ovl_pkg::MEM_COPY_DN: begin
        raddr   = idx_p1[ovl_pkg::ADDR_W-1:0];
        re      = 1'b1;
        wv_next = 1'b1;
      end
      ovl_pkg::MEM_PUT_FRONT: begin
        wv_next    = 1'b1;
        waddr_next = '0;
        wput_next  = 1'b1;
      end
      ovl_pkg::MEM_PUT_BACK: begin
        wv_next    = 1'b1;
        waddr_next = count[ovl_pkg::ADDR_W-1:0];
        wput_next  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wv) begin
      mem[waddr] <= wput ? val : rdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
    waddr <= waddr_next;
    wput  <= wput_next;
    if (cmd.take) begin
      val <= req_value;
    end
    cmp_idx <= idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wv        <= 1'b0;
      cmp_valid <= 1'b0;
      count     <= '0;
      idx       <= '0;
    end else begin
      wv        <= wv_next;
      cmp_valid <= (cmd.mem_op == ovl_pkg::MEM_READ);
      unique case (cmd.cnt_op)
        ovl_pkg::CNT_INC: count <= count + ovl_pkg::CNT_W'(1);
        ovl_pkg::CNT_DEC: count <= count_m1;
        default: ;
      endcase
      unique case (cmd.idx_op)
        ovl_pkg::IDX_ZERO:  idx <= '0;
        ovl_pkg::IDX_COUNT: idx <= count;
        ovl_pkg::IDX_INC:   idx <= idx_p1;
        ovl_pkg::IDX_DEC:   idx <= idx_m1;
        ovl_pkg::IDX_HIT:   idx <= cmp_idx;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.emit_item)
      ovl_pkg::ITEM_VALUE: item_mux = val;
      ovl_pkg::ITEM_RDATA: item_mux = rdata;
      default:             item_mux = '0;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.emit_status;
      out_item   <= item_mux;
      out_last   <= cmd.emit_last;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.item   = out_item;
  assign rsp.last   = out_last;

  assign sts.count_zero = (count == '0);
  assign sts.count_full = (count >= ovl_pkg::CNT_W'(ovl_pkg::CAPACITY));
  assign sts.idx_zero   = (idx == '0);
  assign sts.idx_last   = (idx == count_m1);
  assign sts.idx_end    = (idx == count);
  assign sts.hit        = cmp_valid && (rdata == val);
  assign sts.cmp_last   = cmp_valid && (cmp_idx == count_m1);
  assign sts.out_free   = out_free;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= ovl_pkg::CNT_W'(ovl_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  a_inc_room: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_op == ovl_pkg::CNT_INC |-> count < ovl_pkg::CNT_W'(ovl_pkg::CAPACITY))
    else $error("insert on a full list");

  a_dec_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.cnt_op == ovl_pkg::CNT_DEC |-> count != '0)
    else $error("removal on an empty list");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("word emitted over a pending word");

  a_write_in_list: assert property (@(posedge clk) disable iff (rst)
    wv |-> ovl_pkg::CNT_W'(waddr) <= count)
    else $error("memory write past end of list");

endmodule

@@ rtl/ordered_value_list_core.sv @@
// ordered value list top level: controller and datapath
//
//  channel | dir | payload                 | handshake
//  req     | in  | kind[2:0], value[31:0]  | valid/ready
//  rsp     | out | status[1:0], item[31:0], last | valid/ready
//
// one request at a time; req.ready is high only while the controller is idle
// insert back: written at the tail; insert front: shift all entries up first
// search: scan from the head to a hit; remove: scan, then shift entries down
// dump: entries read in turn through the single registered memory read port
// reset clears the entry count; rsp stalls hold the walk in place
module ordered_value_list_core (
  input  logic      clk,
  input  logic      rst,
  ovl_in_if.sink    req,
  ovl_out_if.source rsp
);

  ovl_pkg::ovl_cmd_t cmd;
  ovl_pkg::ovl_sts_t sts;

  ovl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ovl_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req_value (req.value),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

endmodule

@@ tb/tb.sv @@
// testbench for ordered_value_list_core: directed list cases, then random traffic
module tb;

  typedef logic signed [ovl_pkg::DATA_W-1:0] value_t;

  typedef struct {
    logic [1:0] status;
    value_t     item;
    logic       last;
  } rsp_word_t;

  localparam int SETTLE_CYCLES = 4 * ovl_pkg::CAPACITY + 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  ovl_in_if  req_if();
  ovl_out_if rsp_if();

  ordered_value_list_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  value_t    shadow_list[$];
  rsp_word_t pending_words[$];
  int        mismatch_count = 0;
  bit        no_idle = 1'b0;

  function automatic void queue_word(logic [1:0] status, value_t item, logic last);
    rsp_word_t w;
    w.status = status;
    w.item   = item;
    w.last   = last;
    pending_words.push_back(w);
  endfunction

  function automatic void apply_request(logic [2:0] kind, value_t value);
    int pos;
    case (kind)
      ovl_pkg::KIND_FRONT, ovl_pkg::KIND_BACK: begin
        if (shadow_list.size() >= ovl_pkg::CAPACITY) begin
          queue_word(ovl_pkg::ST_FULL, '0, 1'b1);
        end else begin
          if (kind == ovl_pkg::KIND_FRONT) shadow_list.push_front(value);
          else shadow_list.push_back(value);
          queue_word(ovl_pkg::ST_OK, '0, 1'b1);
        end
      end
      ovl_pkg::KIND_REMOVE, ovl_pkg::KIND_SEARCH: begin
        pos = -1;
        for (int i = 0; i < shadow_list.size(); i++) begin
          if (pos < 0 && shadow_list[i] == value) pos = i;
        end
        if (shadow_list.size() == 0) begin
          queue_word(ovl_pkg::ST_EMPTY, '0, 1'b1);
        end else if (pos < 0) begin
          queue_word(ovl_pkg::ST_NOT_FOUND, '0, 1'b1);
        end else if (kind == ovl_pkg::KIND_SEARCH) begin
          queue_word(ovl_pkg::ST_OK, shadow_list[pos], 1'b1);
        end else begin
          shadow_list.delete(pos);
          queue_word(ovl_pkg::ST_OK, '0, 1'b1);
        end
      end
      ovl_pkg::KIND_DUMP: begin
        if (shadow_list.size() == 0) begin
          queue_word(ovl_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          foreach (shadow_list[i]) begin
            queue_word(ovl_pkg::ST_OK, shadow_list[i], i == shadow_list.size() - 1);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // response side: random stalls and in-order compare
  always @(posedge clk) begin
    rsp_word_t want;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: status %0d item %0d last %0b",
               rsp_if.status, rsp_if.item, rsp_if.last);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, rsp_if.status);
          mismatch_count++;
        end
        if (rsp_if.item !== want.item) begin
          $error("item mismatch: expected %0d, got %0d", want.item, rsp_if.item);
          mismatch_count++;
        end
        if (rsp_if.last !== want.last) begin
          $error("last mismatch: expected %0b, got %0b", want.last, rsp_if.last);
          mismatch_count++;
        end
      end
    end
    rsp_if.ready <= no_idle || ($urandom_range(99) >= 30);
  end

  task automatic send_request(input logic [2:0] kind, input value_t value);
    int gap;
    gap = 0;
    if (!no_idle) begin
      while ($urandom_range(99) < 30) gap++;
    end
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.kind  <= kind;
    req_if.value <= value;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    apply_request(kind, value);
  endtask

  task automatic wait_drain();
    req_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic value_t pick_value();
    int p;
    p = $urandom_range(99);
    if (p < 45 && shadow_list.size() > 0) return shadow_list[$urandom_range(shadow_list.size() - 1)];
    if (p < 70) return value_t'($urandom_range(8)) - 4;
    if (p < 78) begin
      case ($urandom_range(3))
        0: return 32'sh80000000;
        1: return 32'sh7fffffff;
        2: return '0;
        default: return -1;
      endcase
    end
    return value_t'($urandom);
  endfunction

  task automatic test_empty_list();
    send_request(ovl_pkg::KIND_REMOVE, 5);
    send_request(ovl_pkg::KIND_SEARCH, 32'sh80000000);
    send_request(ovl_pkg::KIND_DUMP, '0);
    send_request(3'd5, '0);
    send_request(3'd7, -1);
  endtask

  task automatic test_full_list();
    value_t v;
    for (int i = 0; i < ovl_pkg::CAPACITY; i++) begin
      if (i == 0) v = 32'sh80000000;
      else if (i == 1) v = 32'sh7fffffff;
      else if (i < 5) v = 7;
      else v = value_t'($urandom);
      send_request(i[0] ? ovl_pkg::KIND_BACK : ovl_pkg::KIND_FRONT, v);
    end
    send_request(ovl_pkg::KIND_FRONT, 1);
    send_request(ovl_pkg::KIND_BACK, 2);
    send_request(ovl_pkg::KIND_DUMP, '0);
  endtask

  task automatic test_remove_search();
    send_request(ovl_pkg::KIND_SEARCH, 7);
    send_request(ovl_pkg::KIND_REMOVE, 7);
    send_request(ovl_pkg::KIND_REMOVE, 32'sh7fffffff);
    send_request(ovl_pkg::KIND_SEARCH, -3);
    send_request(ovl_pkg::KIND_REMOVE, -3);
  endtask

  task automatic test_random_traffic(input int count, input bit grow);
    int r;
    int ins_pct;
    logic [2:0] kind;
    ins_pct = grow ? 55 : 20;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < ins_pct) kind = $urandom_range(1) ? ovl_pkg::KIND_BACK : ovl_pkg::KIND_FRONT;
      else if (r < 80) kind = r[0] ? ovl_pkg::KIND_REMOVE : ovl_pkg::KIND_SEARCH;
      else if (r < 95) kind = ovl_pkg::KIND_DUMP;
      else kind = 3'($urandom_range(7, 5));
      send_request(kind, pick_value());
    end
  endtask

  task automatic test_burst_traffic();
    no_idle = 1'b1;
    test_random_traffic(100, 1'b1);
    no_idle = 1'b0;
  endtask

  task automatic test_quiet_restart();
    send_request(ovl_pkg::KIND_DUMP, '0);
    wait_drain();
    test_random_traffic(10, 1'b0);
  endtask

  initial begin
    req_if.valid <= 1'b0;
    req_if.kind  <= ovl_pkg::KIND_FRONT;
    req_if.value <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_full_list();
    test_remove_search();
    test_random_traffic(120, 1'b1);
    test_random_traffic(100, 1'b0);
    test_burst_traffic();
    test_quiet_restart();
    test_random_traffic(110, 1'b0);
    wait_drain();
    if (mismatch_count == 0) begin
      $display("** ordered_value_list_core: PASSED **");
    end else begin
      $display("** ordered_value_list_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** ordered_value_list_core: FAILED **");
    $finish;
  end

endmodule
